@@ design/usmg_pkg.sv @@
// Shared types, constants and helper functions for the UV sphere element generator.
// No dependencies; every other design file but usmg_div refers to this package by scoped names.
`default_nettype none
package usmg_pkg;

  localparam int N_W        = 7;   // subdivision count width
  localparam int E_W        = 12;  // element number width
  localparam int CNT_W      = 14;  // vertex/face counts for n up to 127
  localparam int IDX_W      = 12;  // corner index width
  localparam int POS_W      = 16;  // Q1.15 coordinate
  localparam int PH_W       = 32;  // phase, 2^32 per turn
  localparam int ANG_NUM_W  = N_W + PH_W;
  localparam int ANG_DEN_W  = N_W + 1;
  localparam int CW         = 34;  // CORDIC x/y width
  localparam int ZW         = 34;  // CORDIC angle width
  localparam int PROD_W     = 64;
  localparam int RND_W      = 20;
  localparam int CORDIC_STEPS = 16;
  localparam int QDEPTH     = 4;

  localparam int MAX_SUBDIVS_DEF = 64;
  localparam logic [N_W-1:0] SUBDIV_RESET = 7'd20;
  localparam logic [N_W-1:0] N_MIN        = 7'd3;

  // request kind of an input item
  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_FACE   = 1'b1;

  localparam logic [PH_W-1:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [PH_W-1:0] HALF_TURN    = 32'h8000_0000;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic signed [RND_W-1:0] SAT_HI = 20'sd16384;
  localparam logic signed [RND_W-1:0] SAT_LO = -20'sd16384;
  localparam logic [POS_W-1:0] POS_HALF_P = 16'h4000;
  localparam logic [POS_W-1:0] POS_HALF_N = 16'hC000;

  typedef enum logic [6:0] {
    CLS_OOR       = 7'b0000001,
    CLS_POLE_LO   = 7'b0000010,
    CLS_POLE_HI   = 7'b0000100,
    CLS_RING      = 7'b0001000,
    CLS_FACE_SIDE = 7'b0010000,
    CLS_FACE_TOP  = 7'b0100000,
    CLS_FACE_BOT  = 7'b1000000
  } cls_t;

  // classified item as it travels from the front end to the back end
  typedef struct packed {
    cls_t             cls;
    logic [E_W-1:0]   elem;
    logic [N_W-1:0]   n;
    logic [CNT_W-1:0] vcnt;
  } qent_t;

  // per-item result info carried alongside the angle pipeline
  typedef struct packed {
    cls_t             cls;
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    logic [IDX_W-1:0] c;
    logic [IDX_W-1:0] d;
  } info_t;

  function automatic logic [PH_W-1:0] atan_turn(input int i);
    logic [PH_W-1:0] v;
    unique case (i)
      0:  v = 32'd536870912;
      1:  v = 32'd316933406;
      2:  v = 32'd167458907;
      3:  v = 32'd85004756;
      4:  v = 32'd42667330;
      5:  v = 32'd21354465;
      6:  v = 32'd10679842;
      7:  v = 32'd5340245;
      8:  v = 32'd2670163;
      9:  v = 32'd1335087;
      10: v = 32'd667544;
      11: v = 32'd333772;
      12: v = 32'd166886;
      13: v = 32'd83443;
      14: v = 32'd41722;
      15: v = 32'd20861;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [POS_W-1:0] sat_q15(input logic signed [RND_W-1:0] v);
    logic signed [RND_W-1:0] s;
    if (v > SAT_HI) begin
      s = SAT_HI;
    end else if (v < SAT_LO) begin
      s = SAT_LO;
    end else begin
      s = v;
    end
    return s[POS_W-1:0];
  endfunction

endpackage
`default_nettype wire

@@ design/uv_sphere_mesh_generator.sv @@
// UV sphere element generator: one vertex position or face corner set per accepted item.
// Throughput: one item per cycle while busy is low, set by the bit-per-stage
// dividers and CORDIC pipeline.
// busy is high in the cycle after a configuration write and in the first cycle out of reset.
// Reset is synchronous, active low; subdivisions resets to 20. Results cannot be stalled.
`default_nettype none
module uv_sphere_mesh_generator #(
  parameter int MAX_SUBDIVS = usmg_pkg::MAX_SUBDIVS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_kind,
  input  logic [usmg_pkg::E_W-1:0]      in_element_number,
  input  logic                          cfg_we,
  input  logic [usmg_pkg::N_W-1:0]      cfg_wdata,
  output logic                          out_valid,
  output logic                          out_out_of_range,
  output logic [usmg_pkg::POS_W-1:0]    out_pos_x,
  output logic [usmg_pkg::POS_W-1:0]    out_pos_y,
  output logic [usmg_pkg::POS_W-1:0]    out_pos_z,
  output logic [usmg_pkg::IDX_W-1:0]    out_corner_a,
  output logic [usmg_pkg::IDX_W-1:0]    out_corner_b,
  output logic [usmg_pkg::IDX_W-1:0]    out_corner_c,
  output logic [usmg_pkg::IDX_W-1:0]    out_corner_d
);

  logic            acc;
  logic            fr_vld, fr_stale;
  usmg_pkg::qent_t fr_ent;
  logic            q_vld, q_afull;
  usmg_pkg::qent_t q_ent;

  assign busy = fr_stale | q_afull;
  assign acc  = start & ~busy;

  usmg_front #(.MAX_SUBDIVS(MAX_SUBDIVS)) u_front (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .acc_i(acc), .kind_i(in_kind), .elem_i(in_element_number),
    .vld_o(fr_vld), .ent_o(fr_ent), .stale_o(fr_stale)
  );

  usmg_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push_i(fr_vld), .data_i(fr_ent),
    .vld_o(q_vld), .data_o(q_ent), .afull_o(q_afull)
  );

  usmg_back u_back (
    .clk(clk), .rst_n(rst_n), .vld_i(q_vld), .ent_i(q_ent),
    .out_valid(out_valid), .out_out_of_range(out_out_of_range),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_pos_z(out_pos_z),
    .out_corner_a(out_corner_a), .out_corner_b(out_corner_b),
    .out_corner_c(out_corner_c), .out_corner_d(out_corner_d)
  );

`ifndef ASSERT_OFF
  a_oor_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_out_of_range) |->
      (out_pos_x == '0 && out_pos_y == '0 && out_pos_z == '0 &&
       out_corner_a == '0 && out_corner_b == '0 &&
       out_corner_c == '0 && out_corner_d == '0))
    else $error("out of range item carries nonzero fields");

  a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> busy)
    else $error("item accepted while derived counts were stale");
`endif

endmodule
`default_nettype wire

@@ design/usmg_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, several lanes sharing a sideband.
// Depends on nothing but its parameters.
`default_nettype none
module usmg_div #(
  parameter int NUM_W = 12,
  parameter int DEN_W = 7,
  parameter int SB_W  = 1,
  parameter int LANES = 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          vld_i,
  input  logic [LANES-1:0][NUM_W-1:0]   num_i,
  input  logic [LANES-1:0][DEN_W-1:0]   den_i,
  input  logic [SB_W-1:0]               sb_i,
  output logic                          vld_o,
  output logic [LANES-1:0][NUM_W-1:0]   quo_o,
  output logic [LANES-1:0][DEN_W-1:0]   rem_o,
  output logic [SB_W-1:0]               sb_o
);

  logic                        vld_r [NUM_W];
  logic [LANES-1:0][NUM_W-1:0] num_r [NUM_W];
  logic [LANES-1:0][NUM_W-1:0] quo_r [NUM_W];
  logic [LANES-1:0][DEN_W-1:0] den_r [NUM_W];
  logic [LANES-1:0][DEN_W-1:0] rem_r [NUM_W];
  logic [SB_W-1:0]             sb_r  [NUM_W];

  for (genvar s = 0; s < NUM_W; s++) begin : g_stage
    logic                        vld_in;
    logic [LANES-1:0][NUM_W-1:0] num_in, quo_in, num_nxt, quo_nxt;
    logic [LANES-1:0][DEN_W-1:0] den_in, rem_in, rem_nxt;
    logic [SB_W-1:0]             sb_in;

    if (s == 0) begin : g_first
      assign vld_in = vld_i;
      assign num_in = num_i;
      assign quo_in = '0;
      assign den_in = den_i;
      assign rem_in = '0;
      assign sb_in  = sb_i;
    end else begin : g_next
      assign vld_in = vld_r[s-1];
      assign num_in = num_r[s-1];
      assign quo_in = quo_r[s-1];
      assign den_in = den_r[s-1];
      assign rem_in = rem_r[s-1];
      assign sb_in  = sb_r[s-1];
    end

    always_comb begin
      logic [DEN_W:0] t;
      logic [DEN_W:0] d;
      for (int l = 0; l < LANES; l++) begin
        t = {rem_in[l], num_in[l][NUM_W-1]};
        d = {1'b0, den_in[l]};
        if (t >= d) begin
          rem_nxt[l] = DEN_W'(t - d);
          quo_nxt[l] = {quo_in[l][NUM_W-2:0], 1'b1};
        end else begin
          rem_nxt[l] = t[DEN_W-1:0];
          quo_nxt[l] = {quo_in[l][NUM_W-2:0], 1'b0};
        end
        num_nxt[l] = {num_in[l][NUM_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      num_r[s] <= num_nxt;
      quo_r[s] <= quo_nxt;
      den_r[s] <= den_in;
      rem_r[s] <= rem_nxt;
      sb_r[s]  <= sb_in;
    end
  end

  assign vld_o = vld_r[NUM_W-1];
  assign quo_o = quo_r[NUM_W-1];
  assign rem_o = rem_r[NUM_W-1];
  assign sb_o  = sb_r[NUM_W-1];

endmodule
`default_nettype wire

@@ design/usmg_cordic.sv @@
// Pipelined rotation-mode CORDIC giving cos and sin in Q30 of a 32-bit phase, several lanes.
// Depends on usmg_pkg for widths, gain and the arctangent table.
`default_nettype none
module usmg_cordic #(
  parameter int LANES = 2,
  parameter int SB_W  = 1
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  vld_i,
  input  logic [LANES-1:0][usmg_pkg::PH_W-1:0]  ph_i,
  input  logic [SB_W-1:0]                       sb_i,
  output logic                                  vld_o,
  output logic [LANES-1:0][usmg_pkg::CW-1:0]    cos_o,
  output logic [LANES-1:0][usmg_pkg::CW-1:0]    sin_o,
  output logic [SB_W-1:0]                       sb_o
);

  localparam int STEPS = usmg_pkg::CORDIC_STEPS;
  localparam int CW    = usmg_pkg::CW;
  localparam int ZW    = usmg_pkg::ZW;
  localparam int PH_W  = usmg_pkg::PH_W;

  logic                 vld_r  [0:STEPS];
  logic [SB_W-1:0]      sb_r   [0:STEPS];
  logic                 flip_r [0:STEPS][0:LANES-1];
  logic signed [CW-1:0] x_r    [0:STEPS][0:LANES-1];
  logic signed [CW-1:0] y_r    [0:STEPS][0:LANES-1];
  logic signed [ZW-1:0] z_r    [0:STEPS][0:LANES-1];

  logic                 pre_flip [0:LANES-1];
  logic signed [ZW-1:0] pre_z    [0:LANES-1];

  // fold the phase into [-quarter, quarter) and remember the half-turn flip
  always_comb begin
    logic [PH_W-1:0] rot;
    logic [PH_W-1:0] ph2;
    for (int l = 0; l < LANES; l++) begin
      rot = ph_i[l] + usmg_pkg::QUARTER_TURN;
      pre_flip[l] = rot[PH_W-1];
      ph2 = rot[PH_W-1] ? (ph_i[l] + usmg_pkg::HALF_TURN) : ph_i[l];
      pre_z[l] = ZW'($signed(ph2));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    sb_r[0] <= sb_i;
    for (int l = 0; l < LANES; l++) begin
      flip_r[0][l] <= pre_flip[l];
      x_r[0][l]    <= usmg_pkg::CORDIC_GAIN;
      y_r[0][l]    <= '0;
      z_r[0][l]    <= pre_z[l];
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam logic signed [ZW-1:0] ATAN_Z = ZW'(usmg_pkg::atan_turn(i));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else begin
        vld_r[i+1] <= vld_r[i];
      end
    end

    always_ff @(posedge clk) begin
      sb_r[i+1] <= sb_r[i];
      for (int l = 0; l < LANES; l++) begin
        flip_r[i+1][l] <= flip_r[i][l];
        if (!z_r[i][l][ZW-1]) begin
          x_r[i+1][l] <= x_r[i][l] - (y_r[i][l] >>> i);
          y_r[i+1][l] <= y_r[i][l] + (x_r[i][l] >>> i);
          z_r[i+1][l] <= z_r[i][l] - ATAN_Z;
        end else begin
          x_r[i+1][l] <= x_r[i][l] + (y_r[i][l] >>> i);
          y_r[i+1][l] <= y_r[i][l] - (x_r[i][l] >>> i);
          z_r[i+1][l] <= z_r[i][l] + ATAN_Z;
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      cos_o[l] = flip_r[STEPS][l] ? CW'(-x_r[STEPS][l]) : x_r[STEPS][l];
      sin_o[l] = flip_r[STEPS][l] ? CW'(-y_r[STEPS][l]) : y_r[STEPS][l];
    end
  end

  assign vld_o = vld_r[STEPS];
  assign sb_o  = sb_r[STEPS];

endmodule
`default_nettype wire

@@ design/usmg_queue.sv @@
// Short FIFO between the classifying front end and the arithmetic back end; drains every cycle.
// Depends on usmg_pkg for the entry type and depth.
`default_nettype none
module usmg_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_i,
  input  usmg_pkg::qent_t data_i,
  output logic            vld_o,
  output usmg_pkg::qent_t data_o,
  output logic            afull_o
);

  localparam int QDEPTH = usmg_pkg::QDEPTH;
  localparam int PTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  usmg_pkg::qent_t   mem_r [QDEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              pop;

  // back end never stalls, so the head leaves whenever there is one
  assign pop     = (cnt_r != '0);
  assign vld_o   = pop;
  assign data_o  = mem_r[rd_ptr_r];
  assign afull_o = (cnt_r >= QCNT_W'(QDEPTH - 1));

  always_comb begin
    wr_ptr_nxt = push_i ? PTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop ? PTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt    = QCNT_W'(cnt_r + QCNT_W'(push_i) - QCNT_W'(pop));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= data_i;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push_i && cnt_r == QCNT_W'(QDEPTH)))
    else $error("queue push while full");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0 && !push_i) |=> (cnt_r == QCNT_W'($past(cnt_r) - 1'b1)))
    else $error("queue did not drain its head");
`endif

endmodule
`default_nettype wire

@@ design/usmg_front.sv @@
// Front end: subdivision register, derived counts, and classification of each accepted item.
// Depends on usmg_pkg.
`default_nettype none
module usmg_front #(
  parameter int MAX_SUBDIVS = usmg_pkg::MAX_SUBDIVS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [usmg_pkg::N_W-1:0]  cfg_wdata,
  input  logic                      acc_i,
  input  logic                      kind_i,
  input  logic [usmg_pkg::E_W-1:0]  elem_i,
  output logic                      vld_o,
  output usmg_pkg::qent_t           ent_o,
  output logic                      stale_o
);

  localparam int N_W   = usmg_pkg::N_W;
  localparam int CNT_W = usmg_pkg::CNT_W;
  localparam int MAX_N = (MAX_SUBDIVS > (2**N_W - 1)) ? (2**N_W - 1) : MAX_SUBDIVS;
  localparam logic [N_W-1:0] MAX_NV = N_W'(MAX_N);

  logic [N_W-1:0]   subdiv_r;
  logic             stale_r;
  logic [N_W-1:0]   n_r, n_nxt;
  logic [CNT_W-1:0] vcnt_r, fcnt_r, side_r, top_r;
  logic [CNT_W-1:0] n_ext, n_sq;
  logic             vld_r;
  usmg_pkg::qent_t  ent_r, ent_nxt;
  usmg_pkg::cls_t   cls;
  logic [CNT_W-1:0] e_ext;

  always_comb begin
    if (subdiv_r < usmg_pkg::N_MIN) begin
      n_nxt = usmg_pkg::N_MIN;
    end else if (subdiv_r > MAX_NV) begin
      n_nxt = MAX_NV;
    end else begin
      n_nxt = subdiv_r;
    end
    n_ext = CNT_W'(n_nxt);
    n_sq  = CNT_W'(n_ext * n_ext);
  end

  // derived counts follow the register in the next cycle; stale is high while they lag
  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    fcnt_r <= n_sq;
    vcnt_r <= CNT_W'(n_sq - n_ext + CNT_W'(2));
    side_r <= CNT_W'(n_sq - {n_ext[CNT_W-2:0], 1'b0});
    top_r  <= CNT_W'(n_sq - n_ext);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      subdiv_r <= usmg_pkg::SUBDIV_RESET;
      stale_r  <= 1'b1;
      vld_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        subdiv_r <= cfg_wdata;
      end
      stale_r <= cfg_we;
      vld_r   <= acc_i;
    end
  end

  always_comb begin
    e_ext = CNT_W'(elem_i);
    if (kind_i == usmg_pkg::KIND_VERTEX) begin
      priority if (e_ext >= vcnt_r) begin
        cls = usmg_pkg::CLS_OOR;
      end else if (e_ext == CNT_W'(vcnt_r - CNT_W'(2))) begin
        cls = usmg_pkg::CLS_POLE_LO;
      end else if (e_ext == CNT_W'(vcnt_r - CNT_W'(1))) begin
        cls = usmg_pkg::CLS_POLE_HI;
      end else begin
        cls = usmg_pkg::CLS_RING;
      end
    end else begin
      priority if (e_ext >= fcnt_r) begin
        cls = usmg_pkg::CLS_OOR;
      end else if (e_ext < side_r) begin
        cls = usmg_pkg::CLS_FACE_SIDE;
      end else if (e_ext < top_r) begin
        cls = usmg_pkg::CLS_FACE_TOP;
      end else begin
        cls = usmg_pkg::CLS_FACE_BOT;
      end
    end
    ent_nxt.cls  = cls;
    ent_nxt.elem = elem_i;
    ent_nxt.n    = n_r;
    ent_nxt.vcnt = vcnt_r;
  end

  always_ff @(posedge clk) begin
    if (acc_i) begin
      ent_r <= ent_nxt;
    end
  end

  assign vld_o   = vld_r;
  assign ent_o   = ent_r;
  assign stale_o = stale_r;

endmodule
`default_nettype wire

@@ design/usmg_back.sv @@
// Back end: ring/column split, corner indices, angle phases, CORDIC, products and output.
// Depends on usmg_pkg, usmg_div and usmg_cordic.
`default_nettype none
module usmg_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          vld_i,
  input  usmg_pkg::qent_t               ent_i,
  output logic                          out_valid,
  output logic                          out_out_of_range,
  output logic [usmg_pkg::POS_W-1:0]    out_pos_x,
  output logic [usmg_pkg::POS_W-1:0]    out_pos_y,
  output logic [usmg_pkg::POS_W-1:0]    out_pos_z,
  output logic [usmg_pkg::IDX_W-1:0]    out_corner_a,
  output logic [usmg_pkg::IDX_W-1:0]    out_corner_b,
  output logic [usmg_pkg::IDX_W-1:0]    out_corner_c,
  output logic [usmg_pkg::IDX_W-1:0]    out_corner_d
);

  localparam int N_W    = usmg_pkg::N_W;
  localparam int E_W    = usmg_pkg::E_W;
  localparam int CNT_W  = usmg_pkg::CNT_W;
  localparam int IDX_W  = usmg_pkg::IDX_W;
  localparam int PH_W   = usmg_pkg::PH_W;
  localparam int CW     = usmg_pkg::CW;
  localparam int PROD_W = usmg_pkg::PROD_W;
  localparam int RND_W  = usmg_pkg::RND_W;
  localparam int POS_W  = usmg_pkg::POS_W;
  localparam int ANW    = usmg_pkg::ANG_NUM_W;
  localparam int ADW    = usmg_pkg::ANG_DEN_W;
  localparam int QSB_W  = $bits(usmg_pkg::qent_t);
  localparam int ISB_W  = $bits(usmg_pkg::info_t);
  localparam logic signed [PROD_W-1:0] PROD_RND = PROD_W'(64'sd1 <<< 45);
  localparam logic signed [CW-1:0]     Y_RND    = CW'(34'sd32768);

  // ---- element number / n ----
  logic                      ediv_vld;
  logic [0:0][E_W-1:0]       ediv_quo;
  logic [0:0][N_W-1:0]       ediv_rem;
  logic [QSB_W-1:0]          ediv_sb;

  usmg_div #(.NUM_W(E_W), .DEN_W(N_W), .SB_W(QSB_W), .LANES(1)) u_ediv (
    .clk(clk), .rst_n(rst_n), .vld_i(vld_i),
    .num_i(ent_i.elem), .den_i(ent_i.n), .sb_i(ent_i),
    .vld_o(ediv_vld), .quo_o(ediv_quo), .rem_o(ediv_rem), .sb_o(ediv_sb)
  );

  // ---- corner indices ----
  usmg_pkg::qent_t  ce;
  usmg_pkg::info_t  info_nxt, cs_info_r;
  logic             cs_vld_r;
  logic [N_W-1:0]   ring_nxt, cs_ring_r, cs_col_r, cs_n_r, c2;
  logic [N_W:0]     c_inc;
  logic [CNT_W-1:0] e14, n14, c14, c2_14, base, ca, cb, cc, cd;

  always_comb begin
    ce    = usmg_pkg::qent_t'(ediv_sb);
    c_inc = {1'b0, ediv_rem[0]} + 1'b1;
    c2    = (c_inc == {1'b0, ce.n}) ? '0 : c_inc[N_W-1:0];
    e14   = CNT_W'(ce.elem);
    n14   = CNT_W'(ce.n);
    c14   = CNT_W'(ediv_rem[0]);
    c2_14 = CNT_W'(c2);
    // start of the row holding this column: e - c
    base  = CNT_W'(e14 - c14);
    ca = '0;
    cb = '0;
    cc = '0;
    cd = '0;
    unique case (ce.cls)
      usmg_pkg::CLS_FACE_SIDE: begin
        ca = CNT_W'(e14 + 1'b1);
        cb = CNT_W'(base + c2_14 + 1'b1);
        cc = CNT_W'(base + c2_14 + 1'b1 + n14);
        cd = CNT_W'(e14 + 1'b1 + n14);
      end
      usmg_pkg::CLS_FACE_TOP: begin
        ca = ce.vcnt;
        cb = CNT_W'(c2_14 + 1'b1);
        cc = CNT_W'(c14 + 1'b1);
      end
      usmg_pkg::CLS_FACE_BOT: begin
        ca = CNT_W'(base - n14 + c14 + 1'b1);
        cb = CNT_W'(base - n14 + c2_14 + 1'b1);
        cc = CNT_W'(ce.vcnt - 1'b1);
      end
      usmg_pkg::CLS_OOR, usmg_pkg::CLS_POLE_LO, usmg_pkg::CLS_POLE_HI,
      usmg_pkg::CLS_RING: begin
      end
      default: begin
      end
    endcase
    info_nxt.cls = ce.cls;
    info_nxt.a   = ca[IDX_W-1:0];
    info_nxt.b   = cb[IDX_W-1:0];
    info_nxt.c   = cc[IDX_W-1:0];
    info_nxt.d   = cd[IDX_W-1:0];
    ring_nxt     = N_W'(ediv_quo[0][N_W-1:0] + 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cs_vld_r <= 1'b0;
    end else begin
      cs_vld_r <= ediv_vld;
    end
  end

  always_ff @(posedge clk) begin
    cs_info_r <= info_nxt;
    cs_ring_r <= ring_nxt;
    cs_col_r  <= ediv_rem[0];
    cs_n_r    <= ce.n;
  end

  // ---- phases: lane 0 polar, lane 1 azimuth ----
  logic [1:0][ANW-1:0] anum;
  logic [1:0][ADW-1:0] aden;
  logic                adiv_vld;
  logic [1:0][ANW-1:0] adiv_quo;
  logic [ISB_W-1:0]    adiv_sb;

  always_comb begin
    anum[0] = ANW'({cs_ring_r, {PH_W{1'b0}}} + ANW'(cs_n_r));
    aden[0] = {cs_n_r, 1'b0};
    anum[1] = ANW'({cs_col_r, {PH_W{1'b0}}} + ANW'(cs_n_r >> 1));
    aden[1] = {1'b0, cs_n_r};
  end

  usmg_div #(.NUM_W(ANW), .DEN_W(ADW), .SB_W(ISB_W), .LANES(2)) u_adiv (
    .clk(clk), .rst_n(rst_n), .vld_i(cs_vld_r),
    .num_i(anum), .den_i(aden), .sb_i(cs_info_r),
    .vld_o(adiv_vld), .quo_o(adiv_quo), .rem_o(), .sb_o(adiv_sb)
  );

  logic [1:0][PH_W-1:0] ph;
  logic                 cor_vld;
  logic [1:0][CW-1:0]   cor_cos, cor_sin;
  logic [ISB_W-1:0]     cor_sb;

  assign ph[0] = adiv_quo[0][PH_W-1:0];
  assign ph[1] = adiv_quo[1][PH_W-1:0];

  usmg_cordic #(.LANES(2), .SB_W(ISB_W)) u_cordic (
    .clk(clk), .rst_n(rst_n), .vld_i(adiv_vld), .ph_i(ph), .sb_i(adiv_sb),
    .vld_o(cor_vld), .cos_o(cor_cos), .sin_o(cor_sin), .sb_o(cor_sb)
  );

  // ---- products ----
  logic signed [31:0]       st, cp, sp;
  logic signed [PROD_W-1:0] px_r, pz_r;
  logic signed [CW-1:0]     ct_r;
  usmg_pkg::info_t          mu_info_r;
  logic                     mu_vld_r;

  assign st = $signed(cor_sin[0][31:0]);
  assign cp = $signed(cor_cos[1][31:0]);
  assign sp = $signed(cor_sin[1][31:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mu_vld_r <= 1'b0;
    end else begin
      mu_vld_r <= cor_vld;
    end
  end

  always_ff @(posedge clk) begin
    px_r      <= st * cp;
    pz_r      <= st * sp;
    ct_r      <= $signed(cor_cos[0]);
    mu_info_r <= usmg_pkg::info_t'(cor_sb);
  end

  // ---- rounding, saturation, output select ----
  logic signed [PROD_W-1:0] xs, zs;
  logic signed [CW-1:0]     ys;
  logic [POS_W-1:0]         rx, ry, rz;
  logic                     oor_nxt;
  logic [POS_W-1:0]         px_nxt, py_nxt, pz_nxt;

  logic             out_valid_r, oor_r;
  logic [POS_W-1:0] pos_x_r, pos_y_r, pos_z_r;
  logic [IDX_W-1:0] ca_r, cb_r, cc_r, cd_r;

  always_comb begin
    xs = (px_r + PROD_RND) >>> 46;
    zs = (pz_r + PROD_RND) >>> 46;
    ys = (ct_r + Y_RND) >>> 16;
    rx = usmg_pkg::sat_q15(xs[RND_W-1:0]);
    rz = usmg_pkg::sat_q15(zs[RND_W-1:0]);
    ry = usmg_pkg::sat_q15(ys[RND_W-1:0]);
    oor_nxt = 1'b0;
    px_nxt  = '0;
    py_nxt  = '0;
    pz_nxt  = '0;
    unique case (mu_info_r.cls)
      usmg_pkg::CLS_OOR:     oor_nxt = 1'b1;
      usmg_pkg::CLS_POLE_LO: py_nxt  = usmg_pkg::POS_HALF_N;
      usmg_pkg::CLS_POLE_HI: py_nxt  = usmg_pkg::POS_HALF_P;
      usmg_pkg::CLS_RING: begin
        px_nxt = rx;
        py_nxt = ry;
        pz_nxt = rz;
      end
      usmg_pkg::CLS_FACE_SIDE, usmg_pkg::CLS_FACE_TOP, usmg_pkg::CLS_FACE_BOT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= mu_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    oor_r   <= oor_nxt;
    pos_x_r <= px_nxt;
    pos_y_r <= py_nxt;
    pos_z_r <= pz_nxt;
    ca_r    <= mu_info_r.a;
    cb_r    <= mu_info_r.b;
    cc_r    <= mu_info_r.c;
    cd_r    <= mu_info_r.d;
  end

  assign out_valid        = out_valid_r;
  assign out_out_of_range = oor_r;
  assign out_pos_x        = pos_x_r;
  assign out_pos_y        = pos_y_r;
  assign out_pos_z        = pos_z_r;
  assign out_corner_a     = ca_r;
  assign out_corner_b     = cb_r;
  assign out_corner_c     = cc_r;
  assign out_corner_d     = cd_r;

endmodule
`default_nettype wire
